// ----- sv/tts_pkg.sv -----
// ----------------------------------------------------------------------------
// Timer slot table package
// Slot record, command kinds, slot status and controller states.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_ONCE  = 2'd1,
    ST_PER   = 2'd2,
    ST_DONE  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    K_INS_ONCE = 3'd0,
    K_INS_PER  = 3'd1,
    K_TOGGLE   = 3'd2,
    K_RESET    = 3'd3,
    K_CANCEL   = 3'd4,
    K_FIND     = 3'd5,
    K_TICK     = 3'd6,
    K_NONE     = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  typedef struct packed {
    status_t      status;
    logic [15:0]  action;
    logic [31:0]  deadline;
    logic [15:0]  period;
    logic [7:0]   tag;
  } rec_t;

endpackage

// ----- sv/tts_cell.sv -----
// ----------------------------------------------------------------------------
// Timer slot cell
// Holds one slot record and takes its neighbor's record on each shift.
// ----------------------------------------------------------------------------
module tts_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  tts_pkg::rec_t d,
  output tts_pkg::rec_t q
);

  tts_pkg::rec_t rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec <= '0;
    end else if (shift) begin
      rec <= d;
    end
  end

  assign q = rec;

endmodule

// ----- sv/timer_task_slot_table.sv -----
// ----------------------------------------------------------------------------
// Timer task slot table
// Slot records circulate around a ring of cells past one update head.
// ----------------------------------------------------------------------------
// Each item is scanned past the head in one pass over all slots, then a flush
// state emits the result; toggle and wrapped tick take two passes.
// One item at a time: a new item is taken only in the idle state. A fire
// stalls the ring only while the receiver holds off a full output.
// Reset: all slots empty with zero fields, last tick zero, no item in flight.
module timer_task_slot_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [15:0] action_id,
  input  logic [31:0] interval,
  input  logic [7:0]  tag,
  input  logic [7:0]  slot_id,
  input  logic [31:0] now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  answer,
  output logic        fired,
  output logic [15:0] fire_action,
  output logic [7:0]  fire_tag,
  output logic [7:0]  fire_slot,
  output logic        last
);

  localparam int S  = tts_pkg::SLOTS;
  localparam int IW = tts_pkg::IDX_W;

  tts_pkg::state_t state;
  tts_pkg::kind_t  c_kind;
  logic [15:0] c_act;
  logic [31:0] c_ivl;
  logic [7:0]  c_tag;
  logic [7:0]  c_sid;
  logic [31:0] c_now;
  logic        c_wrap;
  logic [31:0] last_tick;
  logic [IW-1:0] idx;
  logic        pass;
  logic        hit, ins, ok;
  logic [IW-1:0] hit_idx, ins_idx;
  logic        pend_valid;
  logic [15:0] pend_action;
  logic [7:0]  pend_tag, pend_slot;

  tts_pkg::rec_t cq [S];
  tts_pkg::rec_t cd [S];
  tts_pkg::rec_t head, head_next;
  logic shift;

  assign head = cq[0];

  for (genvar i = 0; i < S; i++) begin : g_cell
    if (i == S - 1) begin : g_tail
      assign cd[i] = head_next;
    end else begin : g_mid
      assign cd[i] = cq[i + 1];
    end
    tts_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .d(cd[i]), .q(cq[i]));
  end

  logic        waiting, free, match, sel, in_win, fire;
  logic        do_ins, do_hit, do_ok;
  logic [31:0] lo, hi;
  logic [15:0] new_per;
  logic [7:0]  slot1;
  logic        last_pass, end_rec, out_free;
  logic        out_load;

  assign waiting = (head.status == tts_pkg::ST_ONCE) || (head.status == tts_pkg::ST_PER);
  assign free    = (head.status == tts_pkg::ST_EMPTY) || (head.status == tts_pkg::ST_DONE);
  assign match   = (head.action == c_act);
  assign slot1   = 8'(idx) + 8'd1;
  assign sel     = (c_sid == slot1);
  assign lo      = (c_wrap && pass) ? 32'd0 : last_tick;
  assign hi      = (c_wrap && !pass) ? 32'hFFFF_FFFF : c_now;
  assign in_win  = (head.deadline >= lo) && (head.deadline <= hi);
  assign new_per = (c_ivl != 32'd0) ? c_ivl[15:0] : head.period;

  always_comb begin
    head_next = head;
    do_ins = 1'b0;
    do_hit = 1'b0;
    do_ok  = 1'b0;
    fire   = 1'b0;
    case (c_kind) inside
      tts_pkg::K_INS_ONCE: begin
        if (!ins && free) begin
          do_ins = 1'b1;
          head_next.status   = tts_pkg::ST_ONCE;
          head_next.action   = c_act;
          head_next.period   = c_ivl[15:0];
          head_next.deadline = c_now + c_ivl;
          head_next.tag      = c_tag;
        end
      end
      tts_pkg::K_INS_PER, tts_pkg::K_TOGGLE: begin
        if (c_kind == tts_pkg::K_TOGGLE && !pass) begin
          do_hit = !hit && waiting && match;
        end else if (c_kind == tts_pkg::K_TOGGLE && hit) begin
          if (idx == hit_idx) head_next.status = tts_pkg::ST_DONE;
        end else if (!ins && free) begin
          do_ins = 1'b1;
          head_next.status   = tts_pkg::ST_PER;
          head_next.action   = c_act;
          head_next.period   = c_ivl[15:0];
          head_next.deadline = c_now + {16'd0, c_ivl[15:0]};
          head_next.tag      = c_tag;
        end
      end
      tts_pkg::K_FIND: begin
        do_hit = !hit && waiting && match;
      end
      tts_pkg::K_RESET: begin
        if (sel && match && waiting) begin
          do_ok = 1'b1;
          head_next.period   = new_per;
          head_next.deadline = c_now + {16'd0, new_per};
        end
      end
      tts_pkg::K_CANCEL: begin
        if (sel && match) begin
          do_ok = 1'b1;
          head_next.status = tts_pkg::ST_DONE;
        end
      end
      tts_pkg::K_TICK: begin
        if (waiting && in_win) begin
          fire = 1'b1;
          if (head.status == tts_pkg::ST_PER) begin
            head_next.deadline = c_now + {16'd0, head.period};
          end else begin
            head_next.status = tts_pkg::ST_DONE;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_free  = !out_valid || out_ready;
  assign last_pass = (c_kind == tts_pkg::K_TOGGLE || (c_kind == tts_pkg::K_TICK && c_wrap))
                     ? pass : 1'b1;
  assign end_rec   = (idx == IW'(S - 1));
  assign shift     = (state == tts_pkg::S_SCAN) && (!(fire && pend_valid) || out_free);
  assign in_ready  = (state == tts_pkg::S_IDLE);

  logic [7:0] cmd_ans;
  always_comb begin
    case (c_kind) inside
      tts_pkg::K_INS_ONCE, tts_pkg::K_INS_PER: cmd_ans = ins ? 8'(ins_idx) + 8'd1 : 8'd0;
      tts_pkg::K_TOGGLE: cmd_ans = hit ? 8'd0 : (ins ? 8'(ins_idx) + 8'd1 : 8'd0);
      tts_pkg::K_FIND:   cmd_ans = hit ? 8'(hit_idx) + 8'd1 : 8'd0;
      default:           cmd_ans = {7'd0, ok};
    endcase
  end

  assign out_load = ((state == tts_pkg::S_SCAN) && shift && fire && pend_valid) ||
                    ((state == tts_pkg::S_FLUSH) && out_free &&
                     (c_kind != tts_pkg::K_TICK || pend_valid));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tts_pkg::S_IDLE;
      last_tick  <= '0;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      idx        <= '0;
      pass       <= 1'b0;
      hit        <= 1'b0;
      ins        <= 1'b0;
      ok         <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        tts_pkg::S_IDLE: begin
          if (in_valid && kind != tts_pkg::K_NONE) begin
            state      <= tts_pkg::S_SCAN;
            idx        <= '0;
            pass       <= 1'b0;
            hit        <= 1'b0;
            ins        <= 1'b0;
            ok         <= 1'b0;
            pend_valid <= 1'b0;
          end
        end
        tts_pkg::S_SCAN: begin
          if (shift) begin
            if (do_hit) begin
              hit     <= 1'b1;
              hit_idx <= idx;
            end
            if (do_ins) begin
              ins     <= 1'b1;
              ins_idx <= idx;
            end
            if (do_ok) ok <= 1'b1;
            if (fire) begin
              pend_valid  <= 1'b1;
              pend_action <= head.action;
              pend_tag    <= head.tag;
              pend_slot   <= slot1;
            end
            if (end_rec) begin
              idx <= '0;
              if (last_pass) state <= tts_pkg::S_FLUSH;
              else           pass  <= 1'b1;
            end else begin
              idx <= idx + IW'(1);
            end
          end
        end
        tts_pkg::S_FLUSH: begin
          if (c_kind == tts_pkg::K_TICK) last_tick <= c_now;
          if (out_load || (c_kind == tts_pkg::K_TICK && !pend_valid)) begin
            state      <= tts_pkg::S_IDLE;
            pend_valid <= 1'b0;
          end
        end
        default: state <= tts_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == tts_pkg::S_IDLE && in_valid) begin
      c_kind <= tts_pkg::kind_t'(kind);
      c_act  <= action_id;
      c_ivl  <= interval;
      c_tag  <= tag;
      c_sid  <= slot_id;
      c_now  <= now;
      c_wrap <= (last_tick > now);
    end
    if (out_load) begin
      if (state == tts_pkg::S_SCAN || c_kind == tts_pkg::K_TICK) begin
        answer      <= 8'd0;
        fired       <= 1'b1;
        fire_action <= pend_action;
        fire_tag    <= pend_tag;
        fire_slot   <= pend_slot;
        last        <= (state == tts_pkg::S_FLUSH);
      end else begin
        answer      <= cmd_ans;
        fired       <= 1'b0;
        fire_action <= 16'd0;
        fire_tag    <= 8'd0;
        fire_slot   <= 8'd0;
        last        <= 1'b1;
      end
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != tts_pkg::S_IDLE) |-> !in_ready)
    else $error("item accepted while busy");
  a_fire_answer: assert property (@(posedge clk) disable iff (rst)
    out_valid && fired |-> answer == 8'd0 && fire_slot != 8'd0)
    else $error("bad fire result");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("output overwritten");

endmodule

// ----- tb/sv/timer_task_slot_table_test.sv -----
// ----------------------------------------------------------------------------
// Timer task slot table regression
// Drives commands and ticks through the slot table and checks every result
// against a behavioral copy of the slot table kept in the bench.
// ----------------------------------------------------------------------------
module timer_task_slot_table_test;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  kind = tts_pkg::K_NONE;
  logic [15:0] action_id = '0;
  logic [31:0] interval = '0;
  logic [7:0]  tag = '0;
  logic [7:0]  slot_id = '0;
  logic [31:0] now = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  answer;
  logic        fired;
  logic [15:0] fire_action;
  logic [7:0]  fire_tag;
  logic [7:0]  fire_slot;
  logic        last;

  typedef struct packed {
    logic [7:0]  answer;
    logic        fired;
    logic [15:0] action;
    logic [7:0]  tag;
    logic [7:0]  slot;
    logic        last;
  } timer_result_t;

  typedef struct {
    tts_pkg::kind_t k;
    logic [15:0] act;
    logic [31:0] ivl;
    logic [7:0]  tg;
    logic [7:0]  sid;
    logic [31:0] tnow;
    int          want_answer;
  } command_row_t;

  timer_task_slot_table dut (.*);

  always #2 clk = ~clk;

  tts_pkg::status_t tbl_status[tts_pkg::SLOTS];
  logic [15:0]   tbl_action[tts_pkg::SLOTS];
  logic [31:0]   tbl_deadline[tts_pkg::SLOTS];
  logic [15:0]   tbl_period[tts_pkg::SLOTS];
  logic [7:0]    tbl_tag[tts_pkg::SLOTS];
  logic [31:0]   tbl_last_tick;
  timer_result_t pending_results[$];
  int            errors = 0;
  int            cycle_count = 0;
  bit            quiet_phase = 1'b0;
  bit            hold_off = 1'b0;
  logic [31:0]   clock_now = 32'd0;

  task automatic report(input string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  function automatic bit waiting(input int i);
    return tbl_status[i] == tts_pkg::ST_ONCE || tbl_status[i] == tts_pkg::ST_PER;
  endfunction

  function automatic timer_result_t answer_item(input logic [7:0] a);
    timer_result_t r;
    r = '0;
    r.answer = a;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic logic [7:0] insert_slot(input logic [15:0] act, input logic [31:0] dly,
                                             input tts_pkg::status_t st, input logic [7:0] tg,
                                             input logic [31:0] tnow);
    for (int i = 0; i < tts_pkg::SLOTS; i++) begin
      if (tbl_status[i] == tts_pkg::ST_EMPTY || tbl_status[i] == tts_pkg::ST_DONE) begin
        tbl_action[i] = act;
        tbl_period[i] = dly[15:0];
        tbl_deadline[i] = tnow + dly;
        tbl_tag[i] = tg;
        tbl_status[i] = st;
        return 8'(i + 1);
      end
    end
    return 8'd0;
  endfunction

  function automatic logic [7:0] find_slot(input logic [15:0] act);
    for (int i = 0; i < tts_pkg::SLOTS; i++)
      if (tbl_action[i] == act && waiting(i)) return 8'(i + 1);
    return 8'd0;
  endfunction

  function automatic void fire_window(input logic [31:0] lo, input logic [31:0] hi,
                                      input logic [31:0] tnow);
    timer_result_t r;
    for (int i = 0; i < tts_pkg::SLOTS; i++) begin
      if (waiting(i) && tbl_deadline[i] >= lo && tbl_deadline[i] <= hi) begin
        if (tbl_status[i] == tts_pkg::ST_PER) tbl_deadline[i] = tnow + 32'(tbl_period[i]);
        else tbl_status[i] = tts_pkg::ST_DONE;
        r = '0;
        r.fired = 1'b1;
        r.action = tbl_action[i];
        r.tag = tbl_tag[i];
        r.slot = 8'(i + 1);
        pending_results.push_back(r);
      end
    end
  endfunction

  // returns the answer for commands, -1 where no single answer exists
  function automatic int predict_timer(input command_row_t c);
    logic [7:0] a;
    int         n0;
    int         s;
    a = 8'd0;
    s = int'(c.sid) - 1;
    case (c.k)
      tts_pkg::K_INS_ONCE: a = insert_slot(c.act, c.ivl, tts_pkg::ST_ONCE, c.tg, c.tnow);
      tts_pkg::K_INS_PER:
        a = insert_slot(c.act, {16'd0, c.ivl[15:0]}, tts_pkg::ST_PER, c.tg, c.tnow);
      tts_pkg::K_TOGGLE: begin
        a = find_slot(c.act);
        if (a != 0) begin
          tbl_status[a - 1] = tts_pkg::ST_DONE;
          a = 8'd0;
        end else a = insert_slot(c.act, {16'd0, c.ivl[15:0]}, tts_pkg::ST_PER, c.tg, c.tnow);
      end
      tts_pkg::K_RESET:
        if (c.sid >= 1 && c.sid <= tts_pkg::SLOTS && tbl_action[s] == c.act && waiting(s)) begin
          if (c.ivl != 0) tbl_period[s] = c.ivl[15:0];
          tbl_deadline[s] = c.tnow + 32'(tbl_period[s]);
          a = 8'd1;
        end
      tts_pkg::K_CANCEL:
        if (c.sid >= 1 && c.sid <= tts_pkg::SLOTS && tbl_action[s] == c.act) begin
          tbl_status[s] = tts_pkg::ST_DONE;
          a = 8'd1;
        end
      tts_pkg::K_FIND: a = find_slot(c.act);
      tts_pkg::K_TICK: begin
        n0 = pending_results.size();
        if (tbl_last_tick > c.tnow) begin
          fire_window(tbl_last_tick, 32'hFFFF_FFFF, c.tnow);
          tbl_last_tick = 32'd0;
        end
        fire_window(tbl_last_tick, c.tnow, c.tnow);
        tbl_last_tick = c.tnow;
        if (pending_results.size() > n0)
          pending_results[pending_results.size() - 1].last = 1'b1;
        return -1;
      end
      default: return -1;
    endcase
    pending_results.push_back(answer_item(a));
    return int'(a);
  endfunction

  task automatic send_command(input command_row_t c);
    int got;
    while (!quiet_phase && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    kind <= c.k;
    action_id <= c.act;
    interval <= c.ivl;
    tag <= c.tg;
    slot_id <= c.sid;
    now <= c.tnow;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = predict_timer(c);
    if (c.want_answer >= 0 && got != c.want_answer)
      report($sformatf("typed answer %0d, predicted %0d", c.want_answer, got));
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (2 * tts_pkg::SLOTS + 8) @(negedge clk);
  endtask

  function automatic command_row_t row(input tts_pkg::kind_t k, input logic [15:0] act,
                                       input logic [31:0] ivl, input logic [7:0] tg,
                                       input logic [7:0] sid, input logic [31:0] tnow,
                                       input int want);
    command_row_t c;
    c.k = k; c.act = act; c.ivl = ivl; c.tg = tg; c.sid = sid; c.tnow = tnow;
    c.want_answer = want;
    return c;
  endfunction

  function automatic command_row_t random_command;
    command_row_t c;
    int p;
    p = $urandom_range(99);
    c.act = 16'($urandom_range(7));
    if ($urandom_range(9) == 0) c.act = 16'($urandom);
    c.ivl = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(40));
    c.tg = 8'($urandom);
    c.sid = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(tts_pkg::SLOTS + 1));
    if ($urandom_range(30) == 0) clock_now = clock_now - 32'($urandom_range(100));
    else if ($urandom_range(40) == 0) clock_now = $urandom;
    else clock_now = clock_now + 32'($urandom_range(12));
    c.tnow = clock_now;
    c.want_answer = -1;
    if (p < 15) c.k = tts_pkg::K_INS_ONCE;
    else if (p < 27) c.k = tts_pkg::K_INS_PER;
    else if (p < 35) c.k = tts_pkg::K_TOGGLE;
    else if (p < 45) c.k = tts_pkg::K_RESET;
    else if (p < 55) c.k = tts_pkg::K_CANCEL;
    else if (p < 62) c.k = tts_pkg::K_FIND;
    else if (p < 98) c.k = tts_pkg::K_TICK;
    else c.k = tts_pkg::K_NONE;
    return c;
  endfunction

  always @(posedge clk) begin
    timer_result_t seen;
    timer_result_t exp_r;
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && out_ready) begin
      seen = '{answer, fired, fire_action, fire_tag, fire_slot, last};
      if (pending_results.size() == 0) report("result with nothing expected");
      else begin
        exp_r = pending_results.pop_front();
        if (seen.answer != exp_r.answer)
          report($sformatf("answer %0d, expected %0d", seen.answer, exp_r.answer));
        if (seen.fired != exp_r.fired)
          report($sformatf("fired %0d, expected %0d", seen.fired, exp_r.fired));
        if (seen.action != exp_r.action)
          report($sformatf("fire_action %h, expected %h", seen.action, exp_r.action));
        if (seen.tag != exp_r.tag)
          report($sformatf("fire_tag %h, expected %h", seen.tag, exp_r.tag));
        if (seen.slot != exp_r.slot)
          report($sformatf("fire_slot %0d, expected %0d", seen.slot, exp_r.slot));
        if (seen.last != exp_r.last)
          report($sformatf("last %0d, expected %0d", seen.last, exp_r.last));
      end
    end
  end

  always @(negedge clk)
    out_ready <= !hold_off && (quiet_phase || $urandom_range(99) >= 22);

  always @(posedge clk)
    if (cycle_count > 1_000_000) begin
      $display("timer_task_slot_table regression: fail");
      $finish;
    end

  command_row_t directed[] = '{
    row(tts_pkg::K_FIND,     16'h0001, 32'd0,         8'h00, 8'd0,   32'd0,         0),
    row(tts_pkg::K_INS_ONCE, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 8'd0,   32'd0,         1),
    row(tts_pkg::K_INS_PER,  16'h0000, 32'h0001_0005, 8'h00, 8'd0,   32'd0,         2),
    row(tts_pkg::K_INS_ONCE, 16'h1234, 32'd3,         8'hA5, 8'd0,   32'd0,         3),
    row(tts_pkg::K_FIND,     16'h0000, 32'd0,         8'h00, 8'd0,   32'd0,         2),
    row(tts_pkg::K_TICK,     16'h0000, 32'd0,         8'h00, 8'd0,   32'd4,         -1),
    row(tts_pkg::K_TICK,     16'h0000, 32'd0,         8'h00, 8'd0,   32'd4,         -1),
    row(tts_pkg::K_RESET,    16'h0000, 32'd0,         8'h00, 8'd2,   32'd10,        1),
    row(tts_pkg::K_RESET,    16'h0000, 32'd7,         8'h00, 8'd0,   32'd10,        0),
    row(tts_pkg::K_RESET,    16'h0000, 32'h1234_0002, 8'h00, 8'd17,  32'd10,        0),
    row(tts_pkg::K_RESET,    16'h1234, 32'd0,         8'h00, 8'd3,   32'd10,        0),
    row(tts_pkg::K_RESET,    16'h0000, 32'h0000_0002, 8'h00, 8'd2,   32'd11,        1),
    row(tts_pkg::K_CANCEL,   16'h0000, 32'd0,         8'h00, 8'd5,   32'd11,        1),
    row(tts_pkg::K_CANCEL,   16'h0007, 32'd0,         8'h00, 8'd255, 32'd11,        0),
    row(tts_pkg::K_TOGGLE,   16'h0000, 32'd0,         8'h00, 8'd0,   32'd11,        0),
    row(tts_pkg::K_TOGGLE,   16'h0042, 32'hFFFF_0001, 8'h5A, 8'd0,   32'hFFFF_FFF0, 2),
    row(tts_pkg::K_INS_PER,  16'h0043, 32'd1,         8'h3C, 8'd0,   32'hFFFF_FFFE, 3),
    row(tts_pkg::K_TICK,     16'h0000, 32'd0,         8'h00, 8'd0,   32'hFFFF_FFFF, -1),
    row(tts_pkg::K_TICK,     16'h0000, 32'd0,         8'h00, 8'd0,   32'd2,         -1),
    row(tts_pkg::K_NONE,     16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF,  32'hFFFF_FFFF, -1),
    row(tts_pkg::K_CANCEL,   16'h0042, 32'd0,         8'h00, 8'd2,   32'd2,         1)
  };

  initial begin
    command_row_t c;
    for (int i = 0; i < tts_pkg::SLOTS; i++) begin
      tbl_status[i] = tts_pkg::ST_EMPTY;
      tbl_action[i] = '0;
      tbl_deadline[i] = '0;
      tbl_period[i] = '0;
      tbl_tag[i] = '0;
    end
    tbl_last_tick = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_command(directed[i]);
    // fill the table past full
    for (int i = 0; i < tts_pkg::SLOTS + 2; i++)
      send_command(row(tts_pkg::K_INS_PER, 16'(100 + i), 32'd1, 8'(i), 8'd0, 32'd3, -1));
    clock_now = 32'd3;
    drain();
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 6; i++) begin
        clock_now = clock_now + 32'd2;
        send_command(row(tts_pkg::K_TICK, 16'd0, 32'd0, 8'd0, 8'd0, clock_now, -1));
      end
    join
    for (int n = 0; n < 330; n++) begin
      quiet_phase = (n >= 120 && n < 190);
      c = random_command();
      send_command(c);
      if (n == 250) drain();
    end
    quiet_phase = 1'b0;
    drain();
    if (errors == 0) $display("timer_task_slot_table regression: pass");
    else $display("timer_task_slot_table regression: fail");
    $finish;
  end

endmodule
